// ----- rtl/urm_pkg.sv -----
// Shared types and constants for the UART register block with receive ring.
package urm_pkg;

  localparam int unsigned RxDepthDefault = 256;

  typedef enum logic [1:0] {
    MODE_RX    = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  localparam logic [11:0] OFS_DR   = 12'h000;
  localparam logic [11:0] OFS_RSR  = 12'h004;
  localparam logic [11:0] OFS_FR   = 12'h018;
  localparam logic [11:0] OFS_IBRD = 12'h024;
  localparam logic [11:0] OFS_FBRD = 12'h028;
  localparam logic [11:0] OFS_LCRH = 12'h02C;
  localparam logic [11:0] OFS_CR   = 12'h030;
  localparam logic [11:0] OFS_IFLS = 12'h034;
  localparam logic [11:0] OFS_IMSC = 12'h038;
  localparam logic [11:0] OFS_RIS  = 12'h03C;
  localparam logic [11:0] OFS_MIS  = 12'h040;
  localparam logic [11:0] OFS_ICR  = 12'h044;

  localparam logic [10:0] INT_RX    = 11'h010;
  localparam logic [10:0] INT_TX    = 11'h020;
  localparam logic [15:0] FLAG_RXFE = 16'h0010;
  localparam logic [15:0] FLAG_RXFF = 16'h0040;
  localparam logic [15:0] FLAG_TXFE = 16'h0080;

  localparam logic [10:0] CR_RESET = 11'h301;

  // Result of one word before the ring byte is merged in.
  typedef struct packed {
    logic [15:0] read_data;
    logic        pop;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;
  } res_t;

endpackage

// ----- rtl/urm_rx_ram.sv -----
// Receive ring storage: one write port, one read port, registered read data.
module urm_rx_ram #(
  parameter int unsigned RX_DEPTH = urm_pkg::RxDepthDefault,
  localparam int unsigned AW = $clog2(RX_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [RX_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/urm_regs.sv -----
// Register file, ring pointers and per-word decode of line bytes and bus accesses.
module urm_regs #(
  parameter int unsigned RX_DEPTH = urm_pkg::RxDepthDefault,
  localparam int unsigned AW = $clog2(RX_DEPTH),
  localparam int unsigned FW = $clog2(RX_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic [1:0]    mode_i,
  input  logic [11:0]   offset_i,
  input  logic [15:0]   write_data_i,
  input  logic [7:0]    rx_byte_i,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output logic [7:0]    wdata_o,
  output logic          re_o,
  output logic [AW-1:0] raddr_o,
  output urm_pkg::res_t res_o
);

  logic [AW-1:0] rd_pos_q, rd_pos_d, wr_pos_q, wr_pos_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [3:0]    rsr_q, rsr_d;
  logic [15:0]   ibrd_q, ibrd_d;
  logic [5:0]    fbrd_q, fbrd_d;
  logic [7:0]    lcrh_q, lcrh_d;
  logic [10:0]   cr_q, cr_d;
  logic [5:0]    ifls_q, ifls_d;
  logic [10:0]   imsc_q, imsc_d;
  logic [10:0]   ris_q, ris_d;
  logic          empty, full;
  logic [AW-1:0] rd_pos_inc, wr_pos_inc;

  assign empty = (fill_q == '0);
  assign full  = (fill_q == FW'(RX_DEPTH));
  assign rd_pos_inc = (rd_pos_q == AW'(RX_DEPTH - 1)) ? '0 : rd_pos_q + 1'b1;
  assign wr_pos_inc = (wr_pos_q == AW'(RX_DEPTH - 1)) ? '0 : wr_pos_q + 1'b1;

  assign waddr_o = wr_pos_q;
  assign wdata_o = rx_byte_i;
  assign raddr_o = rd_pos_q;

  always_comb begin
    rd_pos_d = rd_pos_q;
    wr_pos_d = wr_pos_q;
    fill_d   = fill_q;
    rsr_d    = rsr_q;
    ibrd_d   = ibrd_q;
    fbrd_d   = fbrd_q;
    lcrh_d   = lcrh_q;
    cr_d     = cr_q;
    ifls_d   = ifls_q;
    imsc_d   = imsc_q;
    ris_d    = ris_q;
    we_o     = 1'b0;
    re_o     = 1'b0;
    res_o    = '0;
    if (acc_i) begin
      unique case (mode_i)
        urm_pkg::MODE_RX: begin
          if (!full) begin
            we_o     = 1'b1;
            wr_pos_d = wr_pos_inc;
            fill_d   = fill_q + 1'b1;
            ris_d    = ris_q | urm_pkg::INT_RX;
          end
        end
        urm_pkg::MODE_READ: begin
          unique case (offset_i)
            urm_pkg::OFS_DR: begin
              res_o.read_data = {4'b0, rsr_q, 8'b0};
              if (!empty) begin
                re_o      = 1'b1;
                res_o.pop = 1'b1;
                rd_pos_d  = rd_pos_inc;
                fill_d    = fill_q - 1'b1;
                if (fill_q == FW'(1)) begin
                  ris_d = ris_q & ~urm_pkg::INT_RX;
                end
              end
            end
            urm_pkg::OFS_RSR:  res_o.read_data = {12'b0, rsr_q};
            urm_pkg::OFS_FR: begin
              res_o.read_data = urm_pkg::FLAG_TXFE
                              | (empty ? urm_pkg::FLAG_RXFE : 16'b0)
                              | (full ? urm_pkg::FLAG_RXFF : 16'b0);
            end
            urm_pkg::OFS_IBRD: res_o.read_data = ibrd_q;
            urm_pkg::OFS_FBRD: res_o.read_data = {10'b0, fbrd_q};
            urm_pkg::OFS_LCRH: res_o.read_data = {8'b0, lcrh_q};
            urm_pkg::OFS_CR:   res_o.read_data = {5'b0, cr_q};
            urm_pkg::OFS_IFLS: res_o.read_data = {10'b0, ifls_q};
            urm_pkg::OFS_IMSC: res_o.read_data = {5'b0, imsc_q};
            urm_pkg::OFS_RIS:  res_o.read_data = {5'b0, ris_q};
            urm_pkg::OFS_MIS:  res_o.read_data = {5'b0, ris_q & imsc_q};
            default:           res_o.read_data = '0;
          endcase
        end
        urm_pkg::MODE_WRITE: begin
          unique case (offset_i)
            urm_pkg::OFS_DR: begin
              res_o.tx_valid = 1'b1;
              res_o.tx_byte  = write_data_i[7:0];
              ris_d          = ris_q | urm_pkg::INT_TX;
            end
            urm_pkg::OFS_RSR:  rsr_d  = write_data_i[3:0];
            urm_pkg::OFS_IBRD: ibrd_d = write_data_i;
            urm_pkg::OFS_FBRD: fbrd_d = write_data_i[5:0];
            urm_pkg::OFS_LCRH: lcrh_d = write_data_i[7:0];
            urm_pkg::OFS_CR:   cr_d   = write_data_i[10:0];
            urm_pkg::OFS_IFLS: ifls_d = write_data_i[5:0];
            urm_pkg::OFS_IMSC: imsc_d = write_data_i[10:0];
            urm_pkg::OFS_ICR:  ris_d  = ris_q & ~write_data_i[10:0];
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    res_o.irq = |(ris_d & imsc_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pos_q <= '0;
      wr_pos_q <= '0;
      fill_q   <= '0;
      rsr_q    <= '0;
      ibrd_q   <= '0;
      fbrd_q   <= '0;
      lcrh_q   <= '0;
      cr_q     <= urm_pkg::CR_RESET;
      ifls_q   <= '0;
      imsc_q   <= '0;
      ris_q    <= '0;
    end else begin
      rd_pos_q <= rd_pos_d;
      wr_pos_q <= wr_pos_d;
      fill_q   <= fill_d;
      rsr_q    <= rsr_d;
      ibrd_q   <= ibrd_d;
      fbrd_q   <= fbrd_d;
      lcrh_q   <= lcrh_d;
      cr_q     <= cr_d;
      ifls_q   <= ifls_d;
      imsc_q   <= imsc_d;
      ris_q    <= ris_d;
    end
  end

endmodule

// ----- rtl/urm_out.sv -----
// Result pipeline: RAM read stage, byte merge and output register.
module urm_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  urm_pkg::res_t res_i,
  input  logic [7:0]    ram_rdata_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [15:0]   read_data_o,
  output logic          tx_valid_o,
  output logic [7:0]    tx_byte_o,
  output logic          irq_level_o
);

  urm_pkg::res_t p1_q;
  logic          p1_v_q, p1_v_d;
  logic          o_v_q, o_v_d;
  logic [15:0]   rd_q;
  logic          txv_q;
  logic [7:0]    txb_q;
  logic          irq_q;
  logic          adv;

  assign adv        = p1_v_q && (!o_v_q || out_ready_i);
  assign in_ready_o = !p1_v_q || !o_v_q || out_ready_i;

  always_comb begin
    p1_v_d = acc_i ? 1'b1 : (adv ? 1'b0 : p1_v_q);
    o_v_d  = adv ? 1'b1 : ((o_v_q && out_ready_i) ? 1'b0 : o_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      p1_v_q <= p1_v_d;
      o_v_q  <= o_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      p1_q <= res_i;
    end
    if (adv) begin
      rd_q  <= p1_q.read_data | (p1_q.pop ? {8'b0, ram_rdata_i} : 16'b0);
      txv_q <= p1_q.tx_valid;
      txb_q <= p1_q.tx_byte;
      irq_q <= p1_q.irq;
    end
  end

  assign out_valid_o = o_v_q;
  assign read_data_o = rd_q;
  assign tx_valid_o  = txv_q;
  assign tx_byte_o   = txb_q;
  assign irq_level_o = irq_q;

endmodule

// ----- rtl/uart_register_model_rx_fifo_top.sv -----
// Pipeline: an accepted input word passes through the RAM read stage and the output register.
// Throughput: one word per cycle; the RAM read stage holds one more word while
// a result waits on out_ready_i, after which the input side stalls.
// Reset: pointers, fill count and registers clear, CR resets to 0x301.
// Ring contents are undefined after reset; there is no clearing pass.
module uart_register_model_rx_fifo_top #(
  parameter int unsigned RX_DEPTH = urm_pkg::RxDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [11:0] offset_i,
  input  logic [15:0] write_data_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        irq_level_o
);

  localparam int unsigned AW = $clog2(RX_DEPTH);

  logic          acc;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;
  urm_pkg::res_t res;

  assign acc = in_valid_i && in_ready_o;

  urm_regs #(
    .RX_DEPTH(RX_DEPTH)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .mode_i      (mode_i),
    .offset_i    (offset_i),
    .write_data_i(write_data_i),
    .rx_byte_i   (rx_byte_i),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .res_o       (res)
  );

  urm_rx_ram #(
    .RX_DEPTH(RX_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  urm_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .res_i      (res),
    .ram_rdata_i(rdata),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .read_data_o(read_data_o),
    .tx_valid_o (tx_valid_o),
    .tx_byte_o  (tx_byte_o),
    .irq_level_o(irq_level_o)
  );

endmodule

// ----- rtl/urm_checker.sv -----
// Port-level assertions for the UART register block, bound to the top level.
module urm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] read_data_o,
  input logic        tx_valid_o,
  input logic [7:0]  tx_byte_o,
  input logic        irq_level_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(read_data_o) && $stable(tx_valid_o) && $stable(tx_byte_o) &&
      $stable(irq_level_o))
    else $error("result word changed while stalled");

  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> tx_byte_o == 8'h00)
    else $error("tx byte nonzero without tx valid");

  a_tx_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_valid_o |-> read_data_o == 16'h0000)
    else $error("data write returned read data");

endmodule

bind uart_register_model_rx_fifo_top urm_checker u_urm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .read_data_o(read_data_o),
  .tx_valid_o (tx_valid_o),
  .tx_byte_o  (tx_byte_o),
  .irq_level_o(irq_level_o)
);

// ----- tb/uart_register_model_rx_fifo_top_tb.sv -----
// Self-checking testbench for the UART register block with receive ring.
module uart_register_model_rx_fifo_top_tb;

  localparam int unsigned RING_DEPTH   = urm_pkg::RxDepthDefault;
  localparam int unsigned RANDOM_WORDS = 600;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam logic [11:0] OFS_UNMAPPED = 12'hFFC;

  typedef struct packed {
    logic [15:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;
  } uart_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = '0;
  logic [11:0] offset = '0;
  logic [15:0] write_data = '0;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] read_data;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        irq_level;

  // predictor state
  logic [7:0]  ring_mem [RING_DEPTH];
  int unsigned ring_rd;
  int unsigned ring_fill;
  logic [3:0]  rsr_q;
  logic [15:0] ibrd_q;
  logic [5:0]  fbrd_q;
  logic [7:0]  lcrh_q;
  logic [10:0] cr_q;
  logic [5:0]  ifls_q;
  logic [10:0] imsc_q;
  logic [10:0] ris_q;

  uart_resp_t  expected_resps [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;

  uart_register_model_rx_fifo_top uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .mode_i       (mode),
    .offset_i     (offset),
    .write_data_i (write_data),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .read_data_o  (read_data),
    .tx_valid_o   (tx_valid),
    .tx_byte_o    (tx_byte),
    .irq_level_o  (irq_level)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** uart_register_model_rx_fifo_top: FAILED **");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [11:0] reg_offset(int unsigned idx);
    case (idx)
      0:       return urm_pkg::OFS_DR;
      1:       return urm_pkg::OFS_RSR;
      2:       return urm_pkg::OFS_FR;
      3:       return urm_pkg::OFS_IBRD;
      4:       return urm_pkg::OFS_FBRD;
      5:       return urm_pkg::OFS_LCRH;
      6:       return urm_pkg::OFS_CR;
      7:       return urm_pkg::OFS_IFLS;
      8:       return urm_pkg::OFS_IMSC;
      9:       return urm_pkg::OFS_RIS;
      10:      return urm_pkg::OFS_MIS;
      default: return urm_pkg::OFS_ICR;
    endcase
  endfunction

  // Applies one word to the register/ring state and returns its response.
  function automatic uart_resp_t predict_uart_word(logic [1:0] m, logic [11:0] ofs,
                                                   logic [15:0] wd, logic [7:0] rb);
    uart_resp_t r;
    r = '0;
    case (m)
      urm_pkg::MODE_RX: begin
        if (ring_fill < RING_DEPTH) begin
          ring_mem[(ring_rd + ring_fill) % RING_DEPTH] = rb;
          ring_fill++;
          ris_q |= urm_pkg::INT_RX;
        end
      end
      urm_pkg::MODE_READ: begin
        case (ofs)
          urm_pkg::OFS_DR: begin
            if (ring_fill > 0) begin
              r.read_data = 16'(ring_mem[ring_rd]);
              ring_rd = (ring_rd + 1) % RING_DEPTH;
              ring_fill--;
              if (ring_fill == 0) ris_q &= ~urm_pkg::INT_RX;
            end
            r.read_data |= 16'(rsr_q) << 8;
          end
          urm_pkg::OFS_RSR:  r.read_data = 16'(rsr_q);
          urm_pkg::OFS_FR: begin
            r.read_data = urm_pkg::FLAG_TXFE;
            if (ring_fill == 0) r.read_data |= urm_pkg::FLAG_RXFE;
            if (ring_fill >= RING_DEPTH) r.read_data |= urm_pkg::FLAG_RXFF;
          end
          urm_pkg::OFS_IBRD: r.read_data = ibrd_q;
          urm_pkg::OFS_FBRD: r.read_data = 16'(fbrd_q);
          urm_pkg::OFS_LCRH: r.read_data = 16'(lcrh_q);
          urm_pkg::OFS_CR:   r.read_data = 16'(cr_q);
          urm_pkg::OFS_IFLS: r.read_data = 16'(ifls_q);
          urm_pkg::OFS_IMSC: r.read_data = 16'(imsc_q);
          urm_pkg::OFS_RIS:  r.read_data = 16'(ris_q);
          urm_pkg::OFS_MIS:  r.read_data = 16'(ris_q & imsc_q);
          default:           r.read_data = '0;
        endcase
      end
      urm_pkg::MODE_WRITE: begin
        case (ofs)
          urm_pkg::OFS_DR: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = wd[7:0];
            ris_q |= urm_pkg::INT_TX;
          end
          urm_pkg::OFS_RSR:  rsr_q  = wd[3:0];
          urm_pkg::OFS_IBRD: ibrd_q = wd;
          urm_pkg::OFS_FBRD: fbrd_q = wd[5:0];
          urm_pkg::OFS_LCRH: lcrh_q = wd[7:0];
          urm_pkg::OFS_CR:   cr_q   = wd[10:0];
          urm_pkg::OFS_IFLS: ifls_q = wd[5:0];
          urm_pkg::OFS_IMSC: imsc_q = wd[10:0];
          urm_pkg::OFS_ICR:  ris_q &= ~wd[10:0];
          default: ;
        endcase
      end
      default: ;
    endcase
    r.irq = |(ris_q & imsc_q);
    return r;
  endfunction

  task automatic send_word(input logic [1:0] m, input logic [11:0] ofs,
                           input logic [15:0] wd, input logic [7:0] rb);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    offset     <= ofs;
    write_data <= wd;
    rx_byte    <= rb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_resps.push_back(predict_uart_word(m, ofs, wd, rb));
  endtask

  // sink-side backpressure
  initial begin : drive_out_ready
    int unsigned run;
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      run = pick_gap();
      if (run > 0) begin
        out_ready <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    uart_resp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_resps.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word: read_data %h tx %b/%h irq %b",
                   read_data, tx_valid, tx_byte, irq_level);
        mismatches++;
      end else begin
        want = expected_resps.pop_front();
        check_field("read_data", read_data, want.read_data);
        check_field("tx_valid", 16'(tx_valid), 16'(want.tx_valid));
        check_field("tx_byte", 16'(tx_byte), 16'(want.tx_byte));
        check_field("irq_level", 16'(irq_level), 16'(want.irq));
      end
    end
  end

  task automatic test_reset_values();
    idle_pct = 30;
    send_word(urm_pkg::MODE_READ, urm_pkg::OFS_CR, '0, '0);
    send_word(urm_pkg::MODE_READ, urm_pkg::OFS_FR, '0, '0);
    send_word(urm_pkg::MODE_READ, urm_pkg::OFS_DR, '0, '0);
    send_word(urm_pkg::MODE_READ, urm_pkg::OFS_ICR, '0, '0);
    send_word(urm_pkg::MODE_READ, OFS_UNMAPPED, '0, '0);
    send_word(MODE_UNUSED, urm_pkg::OFS_DR, 16'hFFFF, 8'hFF);
  endtask

  // write all ones to every offset but DR and read each back, then write an unmapped offset
  task automatic test_register_stores();
    idle_pct = 30;
    for (int unsigned i = 1; i < 12; i++) begin
      send_word(urm_pkg::MODE_WRITE, reg_offset(i), 16'hFFFF, '0);
      send_word(urm_pkg::MODE_READ, reg_offset(i), '0, '0);
    end
    send_word(urm_pkg::MODE_WRITE, OFS_UNMAPPED, 16'hFFFF, '0);
  endtask

  task automatic test_data_path();
    idle_pct = 30;
    send_word(urm_pkg::MODE_RX, '0, '0, 8'h00);
    send_word(urm_pkg::MODE_RX, '0, '0, 8'hFF);
    send_word(urm_pkg::MODE_READ, urm_pkg::OFS_DR, '0, '0);
    send_word(urm_pkg::MODE_READ, urm_pkg::OFS_DR, '0, '0);
    send_word(urm_pkg::MODE_READ, urm_pkg::OFS_DR, '0, '0);
    send_word(urm_pkg::MODE_WRITE, urm_pkg::OFS_DR, 16'hFFFF, '0);
    send_word(urm_pkg::MODE_WRITE, urm_pkg::OFS_DR, 16'hFF00, '0);
    send_word(urm_pkg::MODE_READ, urm_pkg::OFS_MIS, '0, '0);
    send_word(urm_pkg::MODE_WRITE, urm_pkg::OFS_ICR, 16'hFFFF, '0);
    send_word(urm_pkg::MODE_READ, urm_pkg::OFS_RIS, '0, '0);
  endtask

  // fill past full, then drain one past empty
  task automatic test_ring_overflow();
    idle_pct = 15;
    send_word(urm_pkg::MODE_WRITE, urm_pkg::OFS_IMSC, 16'(urm_pkg::INT_RX), '0);
    send_word(urm_pkg::MODE_WRITE, urm_pkg::OFS_RSR, 16'($urandom), '0);
    for (int unsigned i = 0; i < RING_DEPTH + 4; i++)
      send_word(urm_pkg::MODE_RX, 12'($urandom), 16'($urandom), 8'($urandom));
    send_word(urm_pkg::MODE_READ, urm_pkg::OFS_FR, '0, '0);
    send_word(urm_pkg::MODE_READ, urm_pkg::OFS_RIS, '0, '0);
    idle_pct = 0;
    for (int unsigned i = 0; i < RING_DEPTH + 1; i++)
      send_word(urm_pkg::MODE_READ, urm_pkg::OFS_DR, 16'($urandom), 8'($urandom));
    send_word(urm_pkg::MODE_READ, urm_pkg::OFS_FR, '0, '0);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned rx_pct;
    logic [1:0]  m;
    logic [11:0] ofs;
    sent = 0;
    rx_pct = 50;
    while (sent < RANDOM_WORDS) begin
      if (sent % 100 == 0) begin
        case ($urandom_range(2))
          0:       rx_pct = 20;
          1:       rx_pct = 50;
          default: rx_pct = 85;
        endcase
        case ($urandom_range(3))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          2:       idle_pct = 30;
          default: idle_pct = 60;
        endcase
      end
      if ($urandom_range(99) < 4) m = MODE_UNUSED;
      else if ($urandom_range(99) < rx_pct) m = urm_pkg::MODE_RX;
      else if ($urandom_range(99) < 60) m = urm_pkg::MODE_READ;
      else m = urm_pkg::MODE_WRITE;
      if (m == MODE_UNUSED || m == urm_pkg::MODE_RX) ofs = 12'($urandom);
      else if ($urandom_range(99) < 40) ofs = urm_pkg::OFS_DR;
      else if ($urandom_range(99) < 85) ofs = reg_offset($urandom_range(11));
      else ofs = 12'($urandom);
      send_word(m, ofs, 16'($urandom), 8'($urandom));
      if (m != MODE_UNUSED) sent++;
    end
  endtask

  initial begin
    ring_rd   = 0;
    ring_fill = 0;
    rsr_q     = '0;
    ibrd_q    = '0;
    fbrd_q    = '0;
    lcrh_q    = '0;
    cr_q      = urm_pkg::CR_RESET;
    ifls_q    = '0;
    imsc_q    = '0;
    ris_q     = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_register_stores();
    test_data_path();
    test_ring_overflow();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_resps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("** uart_register_model_rx_fifo_top: PASSED **");
    end else begin
      $display("** uart_register_model_rx_fifo_top: FAILED **");
    end
    $finish;
  end

endmodule
